// ----- sv/dpq_pkg.sv -----
// Shared types and constants for the double-ended priority queue.
// No dependencies; imported by double_ended_priority_queue.
package dpq_pkg;

    localparam int DPQ_CAPACITY = 1024;
    localparam int KEY_W        = 32;
    localparam int KIND_W       = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_DEL_MAX = 2'd1,
        KIND_DEL_MIN = 2'd2,
        KIND_CLEAR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_WAIT,
        ST_RD_LO,
        ST_RD_HI,
        ST_FIN
    } t_state;

endpackage

// ----- sv/double_ended_priority_queue.sv -----
// Double-ended priority queue: sorted key ring held in one synchronous RAM.
// Depends on dpq_pkg.
//
// Usage:
//   Slave channel: tuser carries the kind (insert, delete largest, delete
//   smallest, clear), tdata the signed key (used by insert only).
//   Master channel: one result item per input item with the largest and
//   smallest keys, empty flag, entry count and dropped flag.
//   Keys sit in ascending order in a circular buffer; a base pointer marks
//   the smallest. Delete smallest moves the base, delete largest and clear
//   only change the count. Insert walks down from the top, one RAM read and
//   one shifted write per displaced key (ST_INS_CHK reads, ST_INS_WAIT
//   compares and writes). Every item then reads the smallest key (ST_RD_LO)
//   and, unless the queue ends empty, the largest (ST_RD_HI); the result
//   is loaded in ST_FIN. One item is in work at a time; a new item is taken
//   only in ST_IDLE, after the last one has left ST_FIN.
//   The result sits in an output register, so the next item is accepted while
//   the receiver stalls; a finished item waits until that register is free.
//   Reset empties the queue at once; RAM contents need no clearing pass.
module double_ended_priority_queue #(
    parameter  int CAPACITY = dpq_pkg::DPQ_CAPACITY,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int OW       = ((2 * dpq_pkg::KEY_W + CW + 2 + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [dpq_pkg::KEY_W-1:0]  i_s_tdata,   // key
    input  logic [dpq_pkg::KIND_W-1:0] i_s_tuser,   // kind
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [OW-1:0]              o_m_tdata    // largest, smallest, is_empty, entries, dropped
);
    import dpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_state r_state, n_state;

    logic [KEY_W-1:0] mem [CAPACITY];
    logic [KEY_W-1:0] r_rdata;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             wr_en;
    logic [KEY_W-1:0] wr_data;

    logic [AW-1:0]    r_base, n_base;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_pos, n_pos;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_drop, n_drop;
    logic [KEY_W-1:0] r_lo, n_lo;

    logic             r_ovalid;
    logic [OW-1:0]    r_odata, n_odata;
    logic             out_free;
    logic             fin_load;

    // base plus offset, wrapped around the ring
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign fin_load   = (r_state == ST_FIN) && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (t_kind'(i_s_tuser) == KIND_INSERT &&
                        r_count != CW'(CAPACITY)) begin
                        n_state = ST_INS_CHK;
                    end else begin
                        n_state = ST_RD_LO;
                    end
                end
            end
            ST_INS_CHK: begin
                n_state = (r_pos == '0) ? ST_RD_LO : ST_INS_WAIT;
            end
            ST_INS_WAIT: begin
                n_state = ($signed(r_rdata) > $signed(r_key)) ? ST_INS_CHK : ST_RD_LO;
            end
            ST_RD_LO: begin
                n_state = (r_count == '0) ? ST_FIN : ST_RD_HI;
            end
            ST_RD_HI: n_state = ST_FIN;
            ST_FIN:   n_state = out_free ? ST_IDLE : ST_FIN;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_base  = r_base;
        n_count = r_count;
        n_pos   = r_pos;
        n_key   = r_key;
        n_drop  = r_drop;
        n_lo    = r_lo;
        wr_en   = 1'b0;
        wr_addr = ring_add(r_base, r_pos[AW-1:0]);
        wr_data = r_key;
        rd_addr = ring_add(r_base, AW'(r_count - CW'(1)));
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_key  = i_s_tdata;
                    n_drop = 1'b0;
                    n_pos  = r_count;
                    case (t_kind'(i_s_tuser))
                        KIND_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_drop = 1'b1;
                            end
                        end
                        KIND_DEL_MAX: begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        KIND_DEL_MIN: begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                                n_base  = ring_add(r_base, AW'(1));
                            end
                        end
                        default: n_count = '0;
                    endcase
                end
            end
            ST_INS_CHK: begin
                rd_addr = ring_add(r_base, AW'(r_pos - CW'(1)));
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            ST_INS_WAIT: begin
                wr_en = 1'b1;
                if ($signed(r_rdata) > $signed(r_key)) begin
                    wr_data = r_rdata;
                    n_pos   = r_pos - CW'(1);
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ST_RD_LO: rd_addr = r_base;
            ST_RD_HI: n_lo = r_rdata;
            default: ;
        endcase
    end

    // result item packing
    always_comb begin
        n_odata = '0;
        if (r_count == '0) begin
            n_odata[2*KEY_W] = 1'b1;
        end else begin
            n_odata[KEY_W-1:0]       = r_rdata;
            n_odata[2*KEY_W-1:KEY_W] = r_lo;
        end
        n_odata[2*KEY_W+CW:2*KEY_W+1] = r_count;
        n_odata[2*KEY_W+CW+1]         = r_drop;
    end

    // key RAM: up to one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // control and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_count <= n_count;
        end
        r_pos  <= n_pos;
        r_key  <= n_key;
        r_drop <= n_drop;
        r_lo   <= n_lo;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
        if (fin_load) begin
            r_odata <= n_odata;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule
